>>> sv/pws_pkg.sv
// Shared types and constants of the power window statistics block.
package pws_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int FALLBACK_WINDOW   = 60;
  localparam int POWER_W           = 16;
  localparam int RESULT_W          = 15;
  localparam int WINDOW_W          = 16;

  typedef enum logic [0:0] {
    REQ_PUSH  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic push;
    logic query_load;
    logic walk;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

>>> sv/pws_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module pws_div #(
  parameter int SUM_W = 22,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      step_nxt = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? (trial - {1'b0, div_r}) : trial;
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      busy_nxt = (step_r != STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> sv/pws_dp.sv
// Datapath: sample history memory, window walk, accumulators, divider, result register.
module pws_dp #(
  parameter int DEPTH = pws_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pws_pkg::cmd_t                       cmd,
  output pws_pkg::status_t                    status,
  input  logic signed [pws_pkg::POWER_W-1:0]  in_sample_power,
  input  logic        [pws_pkg::WINDOW_W-1:0] in_window_len,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic        [pws_pkg::RESULT_W-1:0] out_avg_power,
  output logic        [pws_pkg::RESULT_W-1:0] out_max_power,
  output logic        [pws_pkg::RESULT_W-1:0] out_min_power
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + pws_pkg::RESULT_W;
  localparam int RW       = pws_pkg::RESULT_W;
  localparam int WW       = pws_pkg::WINDOW_W;
  localparam int FALLBACK =
    (pws_pkg::FALLBACK_WINDOW > DEPTH) ? DEPTH : pws_pkg::FALLBACK_WINDOW;

  logic signed [pws_pkg::POWER_W-1:0] mem [DEPTH];

  logic [AW-1:0]    newest_r, newest_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic signed [pws_pkg::POWER_W-1:0] rdata_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] pos_cnt_r, pos_cnt_nxt;
  logic [RW-1:0]    max_r, max_nxt;
  logic [RW-1:0]    min_r, min_nxt;
  logic             have_min_r, have_min_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [RW-1:0]    avg_out_r, max_out_r, min_out_r;

  logic [WW-1:0]    win_sel;
  logic [CNT_W-1:0] win_cl, win_eff;
  logic [AW-1:0]    push_slot;
  logic             issue, positive;
  logic             div_busy;
  logic [SUM_W-1:0] quotient;

  assign push_slot = (newest_r == AW'(DEPTH - 1)) ? '0 : newest_r + 1'b1;

  always_comb begin
    if (in_window_len == '0 || {1'b0, in_window_len} > (WW + 1)'(DEPTH)) begin
      win_sel = WW'(FALLBACK);
    end else begin
      win_sel = in_window_len;
    end
  end
  assign win_cl  = win_sel[CNT_W-1:0];
  // the walk covers at most the slots written since reset, so never-written slots are not read
  assign win_eff = (win_cl < fill_r) ? win_cl : fill_r;

  assign issue    = cmd.walk && (cnt_r != '0);
  assign positive = !rdata_r[pws_pkg::POWER_W-1] && (rdata_r != '0);

  always_comb begin
    newest_nxt   = newest_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    rvalid_nxt   = issue;
    sum_nxt      = sum_r;
    pos_cnt_nxt  = pos_cnt_r;
    max_nxt      = max_r;
    min_nxt      = min_r;
    have_min_nxt = have_min_r;
    if (cmd.push) begin
      newest_nxt = push_slot;
      if (fill_r != CNT_W'(DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (cmd.query_load) begin
      ptr_nxt      = newest_r;
      cnt_nxt      = win_eff;
      sum_nxt      = '0;
      pos_cnt_nxt  = '0;
      max_nxt      = '0;
      min_nxt      = '0;
      have_min_nxt = 1'b0;
    end
    if (issue) begin
      ptr_nxt = (ptr_r == '0) ? AW'(DEPTH - 1) : ptr_r - 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
    if (rvalid_r && positive) begin
      sum_nxt     = sum_r + SUM_W'(rdata_r[RW-1:0]);
      pos_cnt_nxt = pos_cnt_r + 1'b1;
      if (rdata_r[RW-1:0] > max_r) begin
        max_nxt = rdata_r[RW-1:0];
      end
      if (!have_min_r || rdata_r[RW-1:0] < min_r) begin
        min_nxt = rdata_r[RW-1:0];
      end
      have_min_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[push_slot] <= in_sample_power;
    end
    if (issue) begin
      rdata_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r    <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      newest_r    <= newest_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    sum_r      <= sum_nxt;
    pos_cnt_r  <= pos_cnt_nxt;
    max_r      <= max_nxt;
    min_r      <= min_nxt;
    have_min_r <= have_min_nxt;
    if (cmd.out_load) begin
      avg_out_r <= (pos_cnt_r == '0) ? '0 : quotient[RW-1:0];
      max_out_r <= max_r;
      min_out_r <= min_r;
    end
  end

  pws_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(sum_r),
    .divisor (pos_cnt_r),
    .busy    (div_busy),
    .quotient(quotient)
  );

  assign status.cnt_zero = (cnt_r == '0);
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_avg_power = avg_out_r;
  assign out_max_power = max_out_r;
  assign out_min_power = min_out_r;

endmodule

>>> sv/pws_ctrl.sv
// Controller state machine: request intake, window walk, divide, result hand-off.
module pws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  input  pws_pkg::status_t    status,
  output pws_pkg::cmd_t       cmd
);

  pws_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = (state_r == pws_pkg::ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pws_pkg::ST_IDLE: begin
        if (accept && in_req_type == pws_pkg::REQ_QUERY) begin
          state_nxt = pws_pkg::ST_WALK;
        end
      end
      pws_pkg::ST_WALK: begin
        if (status.cnt_zero) begin
          state_nxt = pws_pkg::ST_DIV;
        end
      end
      pws_pkg::ST_DIV: begin
        state_nxt = pws_pkg::ST_WAIT;
      end
      pws_pkg::ST_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = pws_pkg::ST_FINISH;
        end
      end
      pws_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = pws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pws_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pws_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.push       = accept && in_req_type == pws_pkg::REQ_PUSH;
        cmd.query_load = accept && in_req_type == pws_pkg::REQ_QUERY;
      end
      pws_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
      end
      pws_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
      end
      pws_pkg::ST_WAIT: begin
        cmd = '0;
      end
      pws_pkg::ST_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/power_window_statistics.sv
// Top level of the power window statistics block.
// A push request writes the sample over the oldest history entry. A query request walks the
// newest min(window, samples pushed since reset) entries, one entry per cycle through the
// history memory read port, then runs a bit-serial divider over clog2(HISTORY_DEPTH+1)+15
// dividend bits (22 at depth 64) for the mean. Requests are stalled while a query is in
// progress; a finished result waits in the output register while the next request is
// accepted. A window of 0 or longer than the history means 60, clamped to HISTORY_DEPTH.
// Power is in 1/8 W units; history entries not written since reset are never walked.
module power_window_statistics #(
  parameter int HISTORY_DEPTH = pws_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic signed [pws_pkg::POWER_W-1:0]  in_sample_power,
  input  logic        [pws_pkg::WINDOW_W-1:0] in_window_len,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [pws_pkg::RESULT_W-1:0] out_avg_power,
  output logic        [pws_pkg::RESULT_W-1:0] out_max_power,
  output logic        [pws_pkg::RESULT_W-1:0] out_min_power
);

  pws_pkg::cmd_t    cmd;
  pws_pkg::status_t status;

  pws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  pws_dp #(
    .DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_sample_power(in_sample_power),
    .in_window_len  (in_window_len),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_avg_power  (out_avg_power),
    .out_max_power  (out_max_power),
    .out_min_power  (out_min_power)
  );

endmodule

>>> sv/pws_checker.sv
// Port-level checker for the power window statistics block, with its bind.
module pws_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pws_pkg::RESULT_W-1:0] out_avg_power,
  input logic [pws_pkg::RESULT_W-1:0] out_max_power,
  input logic [pws_pkg::RESULT_W-1:0] out_min_power
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_avg_power)
      && $stable(out_max_power) && $stable(out_min_power))
    else $error("result changed while stalled");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_power <= out_max_power)
    else $error("min above max");

  a_avg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_min_power != '0 |->
      out_avg_power >= out_min_power && out_avg_power <= out_max_power)
    else $error("mean outside min/max");

  a_no_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_min_power == '0 |-> out_avg_power == '0 && out_max_power == '0)
    else $error("nonzero statistics with no positive sample");

endmodule

bind power_window_statistics pws_checker u_pws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_avg_power(out_avg_power),
  .out_max_power(out_max_power),
  .out_min_power(out_min_power)
);

>>> test/tb_power_window_statistics.sv
// Testbench for power_window_statistics: directed and random push/query traffic, self-checked.
module tb_power_window_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = pws_pkg::HISTORY_DEPTH_DEF;
  localparam int POWER_W         = pws_pkg::POWER_W;
  localparam int RESULT_W        = pws_pkg::RESULT_W;
  localparam int WINDOW_W        = pws_pkg::WINDOW_W;
  localparam int FALLBACK_WINDOW = pws_pkg::FALLBACK_WINDOW;
  localparam int RANDOM_ITEMS    = 1600;
  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int TAIL_CYCLES     = 120;

  typedef struct packed {
    logic [RESULT_W-1:0] avg_pw;
    logic [RESULT_W-1:0] max_pw;
    logic [RESULT_W-1:0] min_pw;
  } power_stats_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_req_type;
  logic signed [POWER_W-1:0]  in_sample_power;
  logic        [WINDOW_W-1:0] in_window_len;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [RESULT_W-1:0] out_avg_power;
  logic        [RESULT_W-1:0] out_max_power;
  logic        [RESULT_W-1:0] out_min_power;

  logic signed [POWER_W-1:0] sample_hist [DEPTH];
  int unsigned               newest_idx;
  power_stats_t              expected_stats_q [$];

  int unsigned err_count;
  int unsigned push_count;
  int unsigned query_count;
  int unsigned stats_checked;
  int unsigned cycle_count;
  int unsigned stall_left;
  logic        rx_quiet = 1'b0;

  power_window_statistics #(.HISTORY_DEPTH(DEPTH)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_sample_power (in_sample_power),
    .in_window_len   (in_window_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_avg_power   (out_avg_power),
    .out_max_power   (out_max_power),
    .out_min_power   (out_min_power)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycle_count,
               expected_stats_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly zero, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (rx_quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end
  end

  function automatic power_stats_t window_stats(input logic [WINDOW_W-1:0] wlen);
    power_stats_t res;
    int unsigned  n;
    int unsigned  sum;
    int unsigned  cnt;
    int           peak;
    int           low;
    bit           have_low;
    int           v;
    n        = wlen;
    sum      = 0;
    cnt      = 0;
    peak     = 0;
    low      = 0;
    have_low = 1'b0;
    if (n == 0 || n > DEPTH) n = FALLBACK_WINDOW;
    if (n > DEPTH) n = DEPTH;
    for (int k = 0; k < n; k++) begin
      v = sample_hist[(newest_idx + DEPTH - k) % DEPTH];
      if (v > 0) begin
        sum += v;
        cnt++;
        if (!have_low || v < low) begin
          low      = v;
          have_low = 1'b1;
        end
      end
      if (v > peak) peak = v;
    end
    res.avg_pw = (cnt > 0) ? RESULT_W'(sum / cnt) : '0;
    res.max_pw = RESULT_W'(peak);
    res.min_pw = RESULT_W'(low);
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    power_stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("[%0t] result with no query outstanding: avg %0d max %0d min %0d",
                   $realtime, out_avg_power, out_max_power, out_min_power);
      end else begin
        want = expected_stats_q.pop_front();
        stats_checked++;
        if (out_avg_power !== want.avg_pw) note_mismatch("avg_power", want.avg_pw, out_avg_power);
        if (out_max_power !== want.max_pw) note_mismatch("max_power", want.max_pw, out_max_power);
        if (out_min_power !== want.min_pw) note_mismatch("min_power", want.min_pw, out_min_power);
      end
    end
  end

  task automatic send_request(input pws_pkg::req_type_t rt,
                              input logic signed [POWER_W-1:0] pw,
                              input logic [WINDOW_W-1:0] wlen);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= rt;
    in_sample_power <= pw;
    in_window_len   <= wlen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rt == pws_pkg::REQ_PUSH) begin
      newest_idx              = (newest_idx + 1) % DEPTH;
      sample_hist[newest_idx] = pw;
      push_count++;
    end else begin
      expected_stats_q.push_back(window_stats(wlen));
      query_count++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_stats_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_history();
    send_request(pws_pkg::REQ_QUERY, '0, 16'd0);
    send_request(pws_pkg::REQ_QUERY, 16'sd5, 16'd1);
  endtask

  task automatic test_field_extremes();
    send_request(pws_pkg::REQ_PUSH, 16'sh7fff, 16'hffff);
    send_request(pws_pkg::REQ_PUSH, 16'sh8000, 16'd0);
    send_request(pws_pkg::REQ_PUSH, 16'sd0, 16'd7);
    send_request(pws_pkg::REQ_PUSH, 16'sd1, 16'd0);
    send_request(pws_pkg::REQ_QUERY, 16'sh8000, 16'd1);
    send_request(pws_pkg::REQ_QUERY, 16'sh7fff, 16'd2);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd3);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd4);
    send_request(pws_pkg::REQ_PUSH, 16'sh7fff, 16'd0);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd1);
  endtask

  task automatic test_window_fallback();
    send_request(pws_pkg::REQ_QUERY, '0, 16'd64);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd65);
    send_request(pws_pkg::REQ_QUERY, '0, 16'hffff);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd60);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd0);
  endtask

  task automatic test_no_positive();
    send_request(pws_pkg::REQ_PUSH, -16'sd5, '0);
    send_request(pws_pkg::REQ_PUSH, -16'sd1, '0);
    send_request(pws_pkg::REQ_PUSH, 16'sd0, '0);
    send_request(pws_pkg::REQ_QUERY, '0, 16'd3);
  endtask

  task automatic test_random_traffic();
    logic signed [POWER_W-1:0] pw;
    logic        [WINDOW_W-1:0] wlen;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) rx_quiet <= ($urandom_range(0, 3) == 0);
      if (i % 250 == 125) wait_drained();
      case ($urandom_range(0, 9)) inside
        [0:3]:   pw = POWER_W'($urandom_range(1, 400));
        4:       pw = POWER_W'($urandom());
        5:       pw = -POWER_W'($urandom_range(1, 32768));
        6:       pw = '0;
        7:       pw = 16'sh7fff;
        8:       pw = 16'sh8000;
        default: pw = POWER_W'($urandom_range(16384, 32767));
      endcase
      case ($urandom_range(0, 9)) inside
        [0:5]:   wlen = WINDOW_W'($urandom_range(1, DEPTH));
        6:       wlen = '0;
        7:       wlen = WINDOW_W'($urandom_range(DEPTH + 1, 65535));
        8:       wlen = WINDOW_W'($urandom());
        default: wlen = WINDOW_W'(DEPTH);
      endcase
      if ($urandom_range(0, 9) < 6) send_request(pws_pkg::REQ_PUSH, pw, wlen);
      else                          send_request(pws_pkg::REQ_QUERY, pw, wlen);
    end
    rx_quiet <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = 1'b0;
    in_sample_power = '0;
    in_window_len   = '0;
    err_count       = 0;
    push_count      = 0;
    query_count     = 0;
    stats_checked   = 0;
    cycle_count     = 0;
    newest_idx      = 0;
    for (int i = 0; i < DEPTH; i++) sample_hist[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_history();
    test_field_extremes();
    test_window_fallback();
    test_no_positive();
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d pushes and %0d queries, %0d results checked, %0d mismatches",
             push_count, query_count, stats_checked, err_count);
    $display("windows from empty to full history, fallback lengths, extreme and all-negative data");
    if (err_count == 0 && expected_stats_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (expected_stats_q.size() != 0)
        $display("%0d query results never arrived", expected_stats_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
